/* hw/rtl/m2m_pkg.sv */
`default_nettype none
package m2m_pkg;

  // delay width; pending time saturates at 2^TIME_BITS - 1 (valid range 14..28)
  localparam int TIME_BITS = 28;
  // MIDI variable-length time: up to four 7-bit groups
  localparam int GRP_N     = 4;
  localparam int TICK_W    = 7 * GRP_N;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // MUS event codes, descriptor bits 6..4
  localparam logic [2:0] EV_RELEASE   = 3'd0;
  localparam logic [2:0] EV_PRESS     = 3'd1;
  localparam logic [2:0] EV_PITCH     = 3'd2;
  localparam logic [2:0] EV_SYSTEM    = 3'd3;
  localparam logic [2:0] EV_CTRL      = 3'd4;
  localparam logic [2:0] EV_SCORE_END = 3'd6;

  // MUS controller numbers
  localparam logic [7:0] CTRL_PATCH     = 8'd0;
  localparam logic [7:0] CTRL_LAST      = 8'd9;
  localparam logic [7:0] SYS_CTRL_FIRST = 8'd10;
  localparam logic [7:0] SYS_CTRL_LAST  = 8'd14;

  // MIDI status nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_PITCH    = 4'hE;

  // end-of-track meta event
  localparam logic [7:0] META_0 = 8'hFF;
  localparam logic [7:0] META_1 = 8'h2F;
  localparam logic [7:0] META_2 = 8'h00;

  localparam logic [3:0] CH_PERC_MUS = 4'd15;
  localparam logic [3:0] CH_PERC_MIDI = 4'd9;

  typedef enum logic [1:0] {
    CMD_EV2 = 2'd0,  // time + two event bytes
    CMD_EV3 = 2'd1,  // time + three event bytes
    CMD_EOT = 2'd2,  // time + end-of-track marker
    CMD_ERR = 2'd3   // single error word
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [TIME_BITS-1:0] ticks;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  // MUS controller number to MIDI controller number
  function automatic logic [6:0] ctrl_map(input logic [3:0] idx);
    logic [6:0] r;
    unique case (idx)
      4'd0:    r = 7'h00;
      4'd1:    r = 7'h20;
      4'd2:    r = 7'h01;
      4'd3:    r = 7'h07;
      4'd4:    r = 7'h0A;
      4'd5:    r = 7'h0B;
      4'd6:    r = 7'h5B;
      4'd7:    r = 7'h5D;
      4'd8:    r = 7'h40;
      4'd9:    r = 7'h43;
      4'd10:   r = 7'h78;
      4'd11:   r = 7'h7B;
      4'd12:   r = 7'h7E;
      4'd13:   r = 7'h7F;
      4'd14:   r = 7'h79;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/m2m_front.sv */
`default_nettype none
module m2m_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    score_byte_i,
  input  wire logic          q_full_i,
  output m2m_pkg::cmd_t      cmd_o,
  output logic               cmd_push_o
);

  typedef enum logic [6:0] {
    PH_DESC  = 7'b0000001,
    PH_KEY   = 7'b0000010,
    PH_VEL   = 7'b0000100,
    PH_CTRL  = 7'b0001000,
    PH_VALUE = 7'b0010000,
    PH_TIME  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_e;

  localparam int TB = m2m_pkg::TIME_BITS;

  phase_e          phase_q, phase_d;
  logic [7:0]      desc_q, desc_d;
  logic [7:0]      key_q, key_d;
  logic [7:0]      ctrl_q, ctrl_d;
  logic [6:0]      vel_q [16];
  logic            vel_we;
  logic [TB-1:0]   pend_q, pend_d;
  logic [TB-1:0]   acc_q, acc_d;

  logic            acc_en;
  logic [7:0]      b;
  logic [2:0]      code;
  logic [3:0]      ch;
  logic [TB-1:0]   acc_new;
  logic [TB:0]     sum;
  logic [TB-1:0]   pend_new;
  logic            evt;  // event command issued, ends with after-event step

  assign acc_en = push_i && !q_full_i;
  assign b      = score_byte_i;
  assign code   = desc_q[6:4];

  always_comb begin
    if (desc_q[3:0] == m2m_pkg::CH_PERC_MUS) begin
      ch = m2m_pkg::CH_PERC_MIDI;
    end else if (desc_q[3:0] == m2m_pkg::CH_PERC_MIDI) begin
      ch = m2m_pkg::CH_PERC_MUS;
    end else begin
      ch = desc_q[3:0];
    end
  end

  // acc*128+v overflows exactly when any of the top seven bits is set
  assign acc_new  = (|acc_q[TB-1:TB-7]) ? m2m_pkg::TIME_MAX : {acc_q[TB-8:0], b[6:0]};
  assign sum      = {1'b0, pend_q} + {1'b0, acc_new};
  assign pend_new = sum[TB] ? m2m_pkg::TIME_MAX : sum[TB-1:0];

  always_comb begin
    phase_d    = phase_q;
    desc_d     = desc_q;
    key_d      = key_q;
    ctrl_d     = ctrl_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    vel_we     = 1'b0;
    evt        = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o.kind  = m2m_pkg::CMD_EV3;
    cmd_o.ticks = pend_q;
    cmd_o.b0    = 8'h00;
    cmd_o.b1    = 8'h00;
    cmd_o.b2    = 8'h00;

    if (acc_en) begin
      unique case (phase_q)
        PH_DESC: begin
          desc_d = b;
          unique case (b[6:4])
            m2m_pkg::EV_RELEASE, m2m_pkg::EV_PRESS, m2m_pkg::EV_PITCH: phase_d = PH_KEY;
            m2m_pkg::EV_SYSTEM, m2m_pkg::EV_CTRL:                      phase_d = PH_CTRL;
            m2m_pkg::EV_SCORE_END: begin
              cmd_push_o = 1'b1;
              cmd_o.kind = m2m_pkg::CMD_EOT;
              cmd_o.b0   = m2m_pkg::META_0;
              cmd_o.b1   = m2m_pkg::META_1;
              cmd_o.b2   = m2m_pkg::META_2;
              pend_d     = '0;
              phase_d    = PH_HALT;
            end
            default: begin
              cmd_push_o = 1'b1;
              cmd_o.kind = m2m_pkg::CMD_ERR;
              phase_d    = PH_HALT;
            end
          endcase
        end
        PH_KEY: begin
          key_d = b;
          unique if (code == m2m_pkg::EV_RELEASE) begin
            evt      = 1'b1;
            cmd_o.b0 = {m2m_pkg::ST_NOTE_OFF, ch};
            cmd_o.b1 = {1'b0, b[6:0]};
          end else if (code == m2m_pkg::EV_PRESS) begin
            if (b[7]) begin
              phase_d = PH_VEL;
            end else begin
              evt      = 1'b1;
              cmd_o.b0 = {m2m_pkg::ST_NOTE_ON, ch};
              cmd_o.b1 = {1'b0, b[6:0]};
              cmd_o.b2 = {1'b0, vel_q[ch]};
            end
          end else begin
            evt      = 1'b1;
            cmd_o.b0 = {m2m_pkg::ST_PITCH, ch};
            cmd_o.b1 = {1'b0, b[0], 6'b0};
            cmd_o.b2 = {1'b0, b[7:1]};
          end
        end
        PH_VEL: begin
          vel_we   = 1'b1;
          evt      = 1'b1;
          cmd_o.b0 = {m2m_pkg::ST_NOTE_ON, ch};
          cmd_o.b1 = {1'b0, key_q[6:0]};
          cmd_o.b2 = {1'b0, b[6:0]};
        end
        PH_CTRL: begin
          ctrl_d = b;
          if (code == m2m_pkg::EV_SYSTEM) begin
            if (b < m2m_pkg::SYS_CTRL_FIRST || b > m2m_pkg::SYS_CTRL_LAST) begin
              cmd_push_o = 1'b1;
              cmd_o.kind = m2m_pkg::CMD_ERR;
              phase_d    = PH_HALT;
            end else begin
              evt      = 1'b1;
              cmd_o.b0 = {m2m_pkg::ST_CTRL, ch};
              cmd_o.b1 = {1'b0, m2m_pkg::ctrl_map(b[3:0])};
            end
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          unique if (ctrl_q == m2m_pkg::CTRL_PATCH) begin
            evt        = 1'b1;
            cmd_o.kind = m2m_pkg::CMD_EV2;
            cmd_o.b0   = {m2m_pkg::ST_PROG, ch};
            cmd_o.b1   = {1'b0, b[6:0]};
          end else if (ctrl_q > m2m_pkg::CTRL_LAST) begin
            cmd_push_o = 1'b1;
            cmd_o.kind = m2m_pkg::CMD_ERR;
            phase_d    = PH_HALT;
          end else begin
            evt      = 1'b1;
            cmd_o.b0 = {m2m_pkg::ST_CTRL, ch};
            cmd_o.b1 = {1'b0, m2m_pkg::ctrl_map(ctrl_q[3:0])};
            cmd_o.b2 = b[7] ? 8'h7F : b;
          end
        end
        PH_TIME: begin
          acc_d = acc_new;
          if (!b[7]) begin
            pend_d  = pend_new;
            acc_d   = '0;
            phase_d = PH_DESC;
          end
        end
        PH_HALT: ;
        default: phase_d = PH_HALT;
      endcase

      if (evt) begin
        cmd_push_o = 1'b1;
        pend_d     = '0;
        acc_d      = '0;
        phase_d    = desc_q[7] ? PH_TIME : PH_DESC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DESC;
      desc_q  <= '0;
      key_q   <= '0;
      ctrl_q  <= '0;
      pend_q  <= '0;
      acc_q   <= '0;
      for (int i = 0; i < 16; i++) begin
        vel_q[i] <= 7'h7F;
      end
    end else begin
      phase_q <= phase_d;
      desc_q  <= desc_d;
      key_q   <= key_d;
      ctrl_q  <= ctrl_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      if (vel_we) begin
        vel_q[ch] <= b[6:0];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/m2m_cmdq.sv */
`default_nettype none
module m2m_cmdq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire m2m_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output m2m_pkg::cmd_head_t head_o
);

  localparam int PW = m2m_pkg::CMDQ_PTR_W;

  m2m_pkg::cmd_t ent_q [m2m_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == (PW+1)'(m2m_pkg::CMDQ_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = ent_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/m2m_back.sv */
`default_nettype none
module m2m_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire m2m_pkg::cmd_head_t head_i,
  output logic                    cmd_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [7:0]              out_byte_o,
  output logic                    last_of_run_o,
  output logic                    end_of_track_o,
  output logic                    error_o,
  output logic [31:0]             track_length_o
);

  logic [m2m_pkg::TICK_W-1:0] t;
  logic [2:0]  nt, ne, total, idx_q;
  logic [1:0]  g, j;
  logic        is_err, in_time, last, adv;
  logic [7:0]  byte_w;
  logic        out_vld_q;
  logic [31:0] cnt_q;

  assign t      = m2m_pkg::TICK_W'(head_i.cmd.ticks);
  assign is_err = (head_i.cmd.kind == m2m_pkg::CMD_ERR);

  // number of variable-length time groups
  always_comb begin
    priority if (is_err)          nt = 3'd0;
    else if (t[27:7] == '0)       nt = 3'd1;
    else if (t[27:14] == '0)      nt = 3'd2;
    else if (t[27:21] == '0)      nt = 3'd3;
    else                          nt = 3'd4;
  end

  always_comb begin
    unique case (head_i.cmd.kind)
      m2m_pkg::CMD_EV2: ne = 3'd2;
      m2m_pkg::CMD_EV3: ne = 3'd3;
      m2m_pkg::CMD_EOT: ne = 3'd3;
      m2m_pkg::CMD_ERR: ne = 3'd1;
      default:          ne = 3'd1;
    endcase
  end

  assign total   = nt + ne;
  assign in_time = (idx_q < nt);
  assign g       = 2'(nt - idx_q - 3'd1);  // most significant group first
  assign j       = 2'(idx_q - nt);
  assign last    = (idx_q == total - 3'd1);

  always_comb begin
    if (in_time) begin
      unique case (g)
        2'd0: byte_w = {1'b0, t[6:0]};
        2'd1: byte_w = {1'b1, t[13:7]};
        2'd2: byte_w = {1'b1, t[20:14]};
        2'd3: byte_w = {1'b1, t[27:21]};
        default: byte_w = '0;
      endcase
    end else if (is_err) begin
      byte_w = 8'h00;
    end else begin
      unique case (j)
        2'd0:    byte_w = head_i.cmd.b0;
        2'd1:    byte_w = head_i.cmd.b1;
        default: byte_w = head_i.cmd.b2;
      endcase
    end
  end

  // output register refills in the cycle its word is taken
  assign adv       = head_i.valid && (!out_vld_q || pop_i);
  assign cmd_pop_o = adv && last;
  assign empty_o   = !out_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_o     <= byte_w;
      last_of_run_o  <= last;
      end_of_track_o <= (head_i.cmd.kind == m2m_pkg::CMD_EOT) && !in_time;
      error_o        <= is_err;
      track_length_o <= is_err ? cnt_q : cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (adv) begin
        out_vld_q <= 1'b1;
        idx_q     <= last ? 3'd0 : idx_q + 3'd1;
        if (!is_err) begin
          cnt_q <= cnt_q + 32'd1;
        end
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mus_to_midi_stream_converter_top.sv */
// MUS score to MIDI track byte converter. Push raw score bytes from the first
// event descriptor on; pop MIDI track bytes. The front end parses one score
// byte per cycle unless the queue is full and hands finished events to a
// two-entry command queue; the back end serializes each command, one output
// byte per cycle unless an unpopped word holds it, into an output register.
// An input byte yields zero to seven output bytes (up to four variable-length
// time bytes plus the event). The back end's one byte per cycle sets the pace:
// bytes that produce nothing are taken one per cycle while earlier events
// drain and the queue has room. With the back end idle, the first word of a
// burst goes via the command queue, then the output register, to the ports.
// full rises only while the command queue holds two events.
// The velocity table resets in the reset cycle itself; there is no clearing
// pass. Each word carries last_of_run on the final byte of an input's burst,
// end_of_track on FF 2F 00, and the running track byte count. A bad event or
// controller yields one word with error set and out_byte zero, then the block
// halts (later pushes are accepted and dropped) until reset.
`default_nettype none
module mus_to_midi_stream_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  score_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             end_of_track_o,
  output logic             error_o,
  output logic [31:0]      track_length_o
);

  m2m_pkg::cmd_t      cmd;
  logic               cmd_push;
  logic               cmd_pop;
  m2m_pkg::cmd_head_t head;

  // front: descriptor parsing, velocity table, delay accumulation
  m2m_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .score_byte_i (score_byte_i),
    .q_full_i     (full),
    .cmd_o        (cmd),
    .cmd_push_o   (cmd_push)
  );

  // decouples parsing from byte serialization
  m2m_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .head_o (head)
  );

  // back: time bytes, event bytes, track count, output register
  m2m_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .cmd_pop_o      (cmd_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_track_o (end_of_track_o),
    .error_o        (error_o),
    .track_length_o (track_length_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/m2m_checker.sv */
`default_nettype none
module m2m_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_of_run_o,
  input wire logic        end_of_track_o,
  input wire logic        error_o,
  input wire logic [31:0] track_length_o
);

  // error word: zero byte, ends its burst, never part of the marker
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (out_byte_o == 8'h00 && last_of_run_o && !end_of_track_o))
    else $error("malformed error word");

  // nothing follows an error word
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && error_o) |=> empty)
    else $error("word after error");

  // final marker byte closes the burst
  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_track_o && out_byte_o == 8'h00) |-> last_of_run_o)
    else $error("end-of-track not last");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(track_length_o)))
    else $error("stalled word changed");

endmodule

bind mus_to_midi_stream_converter_top m2m_checker u_m2m_checker (.*);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Score-to-track converter check. Raw score bytes go in through the push/full
// side; the track words that come out are checked one by one against a
// behavioral model of the converter that runs inside this bench. The model is
// updated at the edge that accepts each score byte, and the words that byte
// causes are queued in order. The block halts for good on score end or on a
// bad event, and reset is applied only once, so the run ends with exactly one
// halting case. Which one is left to the simulator's seed.
module tb_top;

  // event codes the block rejects
  localparam logic [2:0] EV_UNDEF_5 = 3'd5;
  localparam logic [2:0] EV_UNDEF_7 = 3'd7;

  // MUS controller -> MIDI controller, entry i in bits [7*i +: 7]
  localparam logic [15*7-1:0] MIDI_CTRL_OF = {
    7'h79, 7'h7F, 7'h7E, 7'h7B, 7'h78, 7'h43, 7'h40, 7'h5D,
    7'h5B, 7'h0B, 7'h0A, 7'h07, 7'h01, 7'h20, 7'h00
  };

  localparam logic [31:0] TICK_MAX = (32'd1 << m2m_pkg::TIME_BITS) - 32'd1;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int RANDOM_BYTES  = 280;
  localparam int DRAIN_CYCLES  = 100;
  localparam int SHOWN_FAULTS  = 10;

  typedef enum logic [2:0] {
    WAIT_DESC, WAIT_KEY, WAIT_VEL, WAIT_CTRL, WAIT_VALUE, WAIT_TIME, HALTED
  } parse_state_e;

  typedef enum int {
    HALT_SCORE_END, HALT_SCORE_END_DELAYED, HALT_BAD_EVENT, HALT_BAD_SYSTEM,
    HALT_BAD_CTRL
  } halt_kind_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        eot;
    logic        err;
    logic [31:0] count;
  } midi_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  score_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_track;
  logic        error_flag;
  logic [31:0] track_length;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mus_to_midi_stream_converter_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .score_byte_i   (score_byte),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte),
    .last_of_run_o  (last_of_run),
    .end_of_track_o (end_of_track),
    .error_o        (error_flag),
    .track_length_o (track_length)
  );

  // ---------------------------------------------------------------------------
  // Converter model: own copy of the parse state, velocities and counters
  // ---------------------------------------------------------------------------
  parse_state_e parse_state;
  logic [7:0]   cur_desc;
  logic [7:0]   held_key;
  logic [7:0]   held_ctrl;
  logic [6:0]   chan_velocity [16];
  logic [31:0]  pending_ticks;
  logic [31:0]  delay_acc;
  logic [31:0]  track_count;

  midi_word_t word_burst[$];       // words of the byte being modeled
  midi_word_t midi_words_due[$];   // words not yet seen at the output

  int         score_bytes_sent;
  int         midi_words_checked;
  int         faults;
  int         cycles;
  halt_kind_e halt_kind;

  // sender pacing
  int push_gap;
  int push_calm;

  task automatic reset_model();
    parse_state   = WAIT_DESC;
    cur_desc      = 8'h00;
    held_key      = 8'h00;
    held_ctrl     = 8'h00;
    pending_ticks = 32'd0;
    delay_acc     = 32'd0;
    track_count   = 32'd0;
    for (int i = 0; i < 16; i++) chan_velocity[i] = 7'h7F;
  endtask

  function automatic logic [3:0] midi_chan(input logic [3:0] c);
    if (c == m2m_pkg::CH_PERC_MUS) return m2m_pkg::CH_PERC_MIDI;
    if (c == m2m_pkg::CH_PERC_MIDI) return m2m_pkg::CH_PERC_MUS;
    return c;
  endfunction

  task automatic emit_word(input logic [7:0] d, input logic eot);
    midi_word_t w;
    track_count = track_count + 32'd1;
    w.data  = d;
    w.last  = 1'b0;
    w.eot   = eot;
    w.err   = 1'b0;
    w.count = track_count;
    word_burst.push_back(w);
  endtask

  // error word carries the count unchanged, no byte is added to the track
  task automatic emit_error();
    midi_word_t w;
    w.data  = 8'h00;
    w.last  = 1'b0;
    w.eot   = 1'b0;
    w.err   = 1'b1;
    w.count = track_count;
    word_burst.push_back(w);
    parse_state = HALTED;
  endtask

  // variable-length time, most significant group first
  task automatic emit_time();
    logic [6:0]  grp [4];
    int          n;
    logic [31:0] t;
    t = pending_ticks & TICK_MAX;
    n = 0;
    do begin
      grp[n] = t[6:0];
      n = n + 1;
      t = t >> 7;
    end while (t != 32'd0 && n < 4);
    while (n > 1) begin
      n = n - 1;
      emit_word({1'b1, grp[n]}, 1'b0);
    end
    emit_word({1'b0, grp[0]}, 1'b0);
    pending_ticks = 32'd0;
  endtask

  task automatic emit_event(input logic [7:0] status, input logic [7:0] a,
                            input logic [7:0] b, input logic three);
    emit_time();
    emit_word(status, 1'b0);
    emit_word(a, 1'b0);
    if (three) emit_word(b, 1'b0);
  endtask

  task automatic close_event();
    if (parse_state == HALTED) return;
    parse_state = cur_desc[7] ? WAIT_TIME : WAIT_DESC;
    delay_acc = 32'd0;
  endtask

  task automatic predict_midi_words(input logic [7:0] b);
    logic [3:0]  ch;
    logic [31:0] v;
    midi_word_t  w;
    word_burst.delete();
    ch = midi_chan(cur_desc[3:0]);
    case (parse_state)
      WAIT_DESC: begin
        cur_desc = b;
        case (b[6:4])
          m2m_pkg::EV_RELEASE, m2m_pkg::EV_PRESS, m2m_pkg::EV_PITCH:
            parse_state = WAIT_KEY;
          m2m_pkg::EV_SYSTEM, m2m_pkg::EV_CTRL: parse_state = WAIT_CTRL;
          m2m_pkg::EV_SCORE_END: begin
            emit_time();
            emit_word(m2m_pkg::META_0, 1'b1);
            emit_word(m2m_pkg::META_1, 1'b1);
            emit_word(m2m_pkg::META_2, 1'b1);
            parse_state = HALTED;
          end
          default: emit_error();
        endcase
      end
      WAIT_KEY: begin
        held_key = b;
        if (cur_desc[6:4] == m2m_pkg::EV_RELEASE) begin
          emit_event({m2m_pkg::ST_NOTE_OFF, ch}, {1'b0, b[6:0]}, 8'h00, 1'b1);
          close_event();
        end else if (cur_desc[6:4] == m2m_pkg::EV_PRESS) begin
          if (b[7]) begin
            parse_state = WAIT_VEL;
          end else begin
            emit_event({m2m_pkg::ST_NOTE_ON, ch}, {1'b0, b[6:0]},
                       {1'b0, chan_velocity[ch]}, 1'b1);
            close_event();
          end
        end else begin
          emit_event({m2m_pkg::ST_PITCH, ch}, {1'b0, b[0], 6'b0}, {1'b0, b[7:1]}, 1'b1);
          close_event();
        end
      end
      WAIT_VEL: begin
        chan_velocity[ch] = b[6:0];
        emit_event({m2m_pkg::ST_NOTE_ON, ch}, {1'b0, held_key[6:0]}, {1'b0, b[6:0]},
                   1'b1);
        close_event();
      end
      WAIT_CTRL: begin
        held_ctrl = b;
        if (cur_desc[6:4] == m2m_pkg::EV_SYSTEM) begin
          if (b < m2m_pkg::SYS_CTRL_FIRST || b > m2m_pkg::SYS_CTRL_LAST) begin
            emit_error();
          end else begin
            emit_event({m2m_pkg::ST_CTRL, ch}, {1'b0, MIDI_CTRL_OF[b[3:0]*7 +: 7]},
                       8'h00, 1'b1);
            close_event();
          end
        end else begin
          parse_state = WAIT_VALUE;
        end
      end
      WAIT_VALUE: begin
        if (held_ctrl == m2m_pkg::CTRL_PATCH) begin
          emit_event({m2m_pkg::ST_PROG, ch}, {1'b0, b[6:0]}, 8'h00, 1'b0);
          close_event();
        end else if (held_ctrl > m2m_pkg::CTRL_LAST) begin
          emit_error();
        end else begin
          // values with the top bit set are clamped
          emit_event({m2m_pkg::ST_CTRL, ch}, {1'b0, MIDI_CTRL_OF[held_ctrl[3:0]*7 +: 7]},
                     b[7] ? 8'h7F : b, 1'b1);
          close_event();
        end
      end
      WAIT_TIME: begin
        v = {25'd0, b[6:0]};
        if (delay_acc > (TICK_MAX - v) / 32'd128) delay_acc = TICK_MAX;
        else delay_acc = delay_acc * 32'd128 + v;
        if (!b[7]) begin
          if (delay_acc > TICK_MAX - pending_ticks) pending_ticks = TICK_MAX;
          else pending_ticks = pending_ticks + delay_acc;
          delay_acc = 32'd0;
          parse_state = WAIT_DESC;
        end
      end
      default: ;
    endcase
    if (word_burst.size() > 0) begin
      w = word_burst.pop_back();
      w.last = 1'b1;
      word_burst.push_back(w);
    end
    foreach (word_burst[i]) midi_words_due.push_back(word_burst[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Pacing: mostly back to back, some short gaps, a few long ones, and now and
  // then a calm stretch with no gaps at all
  // ---------------------------------------------------------------------------
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One score byte through the push side. push stays high into the next call
  // when no gap follows, so it is never lowered and raised in the same step.
  task automatic push_score_byte(input logic [7:0] b);
    if (push_gap > 0) repeat (push_gap) @(posedge clk);
    push       <= 1'b1;
    score_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_midi_words(b);
    score_bytes_sent++;
    push_gap = idle_len(push_calm);
    if (push_gap > 0) push <= 1'b0;
  endtask

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= SHOWN_FAULTS) $display("%0t  mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Word checker and pop pacing
  // ---------------------------------------------------------------------------
  initial begin : word_checker
    int         stall;
    int         calm;
    midi_word_t got;
    midi_word_t want;
    stall = 0;
    calm  = 0;
    pop   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        got.data  = out_byte;
        got.last  = last_of_run;
        got.eot   = end_of_track;
        got.err   = error_flag;
        got.count = track_length;
        midi_words_checked++;
        if (midi_words_due.size() == 0) begin
          note_fault($sformatf("unexpected word byte %02h last %b eot %b err %b len %0d",
                               got.data, got.last, got.eot, got.err, got.count));
        end else begin
          want = midi_words_due.pop_front();
          if (got.data !== want.data || got.last !== want.last || got.eot !== want.eot ||
              got.err !== want.err || got.count !== want.count)
            note_fault($sformatf(
              "word %0d exp byte %02h last %b eot %b err %b len %0d / got %02h %b %b %b %0d",
              midi_words_checked, want.data, want.last, want.eot, want.err, want.count,
              got.data, got.last, got.eot, got.err, got.count));
        end
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall = stall - 1;
      end else begin
        pop <= 1'b1;
        stall = idle_len(calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               midi_words_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // release with an explicit zero delay, press with the default velocity on
  // the MUS percussion channel, press with its own velocity on channel 9
  task automatic test_note_events();
    push_score_byte({1'b1, m2m_pkg::EV_RELEASE, 4'd0});
    push_score_byte(8'h00);
    push_score_byte(8'h00);
    push_score_byte({1'b0, m2m_pkg::EV_PRESS, m2m_pkg::CH_PERC_MUS});
    push_score_byte(8'h7F);
    push_score_byte({1'b0, m2m_pkg::EV_PRESS, m2m_pkg::CH_PERC_MIDI});
    push_score_byte(8'hFF);
    push_score_byte(8'h00);
  endtask

  // pitch wheel at full scale, then a five-group delay that saturates; the
  // next event has to write it as four time bytes
  task automatic test_pitch_and_long_delay();
    push_score_byte({1'b1, m2m_pkg::EV_PITCH, m2m_pkg::CH_PERC_MIDI});
    push_score_byte(8'hFF);
    repeat (4) push_score_byte(8'hFF);
    push_score_byte(8'h7F);
  endtask

  // last system controller, patch change with top bit set, controller value
  // clamp on the top controller number
  task automatic test_controller_events();
    push_score_byte({1'b0, m2m_pkg::EV_SYSTEM, 4'd14});
    push_score_byte(m2m_pkg::SYS_CTRL_LAST);
    push_score_byte({1'b0, m2m_pkg::EV_CTRL, 4'd0});
    push_score_byte(m2m_pkg::CTRL_PATCH);
    push_score_byte(8'hFF);
    push_score_byte({1'b0, m2m_pkg::EV_CTRL, m2m_pkg::CH_PERC_MUS});
    push_score_byte(m2m_pkg::CTRL_LAST);
    push_score_byte(8'h80);
  endtask

  // ---------------------------------------------------------------------------
  // Random well-formed score
  // ---------------------------------------------------------------------------
  task automatic send_random_delay();
    int n;
    int r;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 1 : (r < 85) ? 2 : $urandom_range(3, 5);
    repeat (n - 1) push_score_byte({1'b1, 7'($urandom_range(0, 127))});
    push_score_byte({1'b0, 7'($urandom_range(0, 127))});
  endtask

  task automatic send_random_event(input logic with_delay);
    logic [3:0] ch;
    logic       delayed;
    logic [7:0] key;
    ch      = 4'($urandom_range(0, 15));
    delayed = with_delay || ($urandom_range(0, 9) < 4);
    case ($urandom_range(0, 4))
      0: begin
        push_score_byte({delayed, m2m_pkg::EV_RELEASE, ch});
        push_score_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        key = 8'($urandom_range(0, 255));
        push_score_byte({delayed, m2m_pkg::EV_PRESS, ch});
        push_score_byte(key);
        if (key[7]) push_score_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        push_score_byte({delayed, m2m_pkg::EV_PITCH, ch});
        push_score_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        push_score_byte({delayed, m2m_pkg::EV_SYSTEM, ch});
        push_score_byte(8'($urandom_range(m2m_pkg::SYS_CTRL_FIRST,
                                           m2m_pkg::SYS_CTRL_LAST)));
      end
      default: begin
        push_score_byte({delayed, m2m_pkg::EV_CTRL, ch});
        push_score_byte(8'($urandom_range(m2m_pkg::CTRL_PATCH, m2m_pkg::CTRL_LAST)));
        push_score_byte(8'($urandom_range(0, 255)));
      end
    endcase
    if (delayed) send_random_delay();
  endtask

  task automatic test_random_score();
    int start;
    start = score_bytes_sent;
    while (score_bytes_sent - start < RANDOM_BYTES) send_random_event(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // One halting case, then bytes that must be dropped without any word
  // ---------------------------------------------------------------------------
  task automatic test_halt_and_ignore();
    logic [3:0] ch;
    logic       flag;
    logic [2:0] bad_code;
    logic [7:0] bad_ctrl;
    ch   = 4'($urandom_range(0, 15));
    flag = 1'($urandom_range(0, 1));
    send_random_event(1'b1);   // leaves a delay pending for score end
    halt_kind = halt_kind_e'($urandom_range(0, 4));
    case (halt_kind)
      HALT_SCORE_END: push_score_byte({1'b0, m2m_pkg::EV_SCORE_END, ch});
      HALT_SCORE_END_DELAYED: push_score_byte({1'b1, m2m_pkg::EV_SCORE_END, ch});
      HALT_BAD_EVENT: begin
        bad_code = $urandom_range(0, 1) ? EV_UNDEF_5 : EV_UNDEF_7;
        push_score_byte({flag, bad_code, ch});
      end
      HALT_BAD_SYSTEM: begin
        bad_ctrl = $urandom_range(0, 1)
                   ? 8'($urandom_range(0, m2m_pkg::SYS_CTRL_FIRST - 1))
                   : 8'($urandom_range(m2m_pkg::SYS_CTRL_LAST + 1, 255));
        push_score_byte({flag, m2m_pkg::EV_SYSTEM, ch});
        push_score_byte(bad_ctrl);
      end
      default: begin
        // value byte is still taken before the error word
        push_score_byte({flag, m2m_pkg::EV_CTRL, ch});
        push_score_byte(8'($urandom_range(m2m_pkg::CTRL_LAST + 1, 255)));
        push_score_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (8) push_score_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    push       = 1'b0;
    score_byte = 8'h00;
    rst_n      = 1'b0;
    push_gap   = 0;
    push_calm  = 0;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_note_events();
    test_pitch_and_long_delay();
    test_controller_events();
    test_random_score();
    test_halt_and_ignore();

    if (push_gap == 0) push <= 1'b0;
    while (midi_words_due.size() != 0) @(posedge clk);
    // catch stray words after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Pushed %0d score bytes, checked %0d track words, score ended by %s; %0d faults.",
             score_bytes_sent, midi_words_checked, halt_kind.name(), faults);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/m2m_pkg.sv
hw/rtl/m2m_front.sv
hw/rtl/m2m_cmdq.sv
hw/rtl/m2m_back.sv
hw/rtl/mus_to_midi_stream_converter_top.sv
hw/rtl/m2m_checker.sv
tb/tb_top.sv
